@@ rtl/assert_macros.svh @@
// assertion macros shared by the scanner rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg)
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

@@ rtl/abx_pkg.sv @@
// shared types and constants for the annex b start code scanner
package abx_pkg;

	localparam int BYTE_W = 8;
	localparam int HIST_DEPTH = 8;
	localparam int ADDR_W = 32;
	localparam int HDR_W = 64;
	localparam int CFG_W = 32;
	localparam int CFG_IDX_W = 1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WINDOW_BASE,
		REG_WINDOW_LENGTH
	} cfg_reg_t;

	typedef struct packed {
		logic [CFG_W-1:0] window_base;
		logic [CFG_W-1:0] window_length;
	} cfg_t;

	typedef struct packed {
		logic              hit;
		logic [ADDR_W-1:0] nal_address;
		logic [HDR_W-1:0]  nal_header;
	} nal_rpt_t;

endpackage

@@ rtl/abx_if.sv @@
// stream interfaces for input bytes and nal reports
interface abx_byte_if;
	logic                          valid;
	logic                          ready;
	logic [abx_pkg::BYTE_W-1:0]    data_byte;
	logic                          restart;

	modport source (output valid, output data_byte, output restart, input ready);
	modport sink (input valid, input data_byte, input restart, output ready);
endinterface

interface abx_nal_if;
	logic                          valid;
	logic                          ready;
	logic [abx_pkg::ADDR_W-1:0]    nal_address;
	logic [abx_pkg::HDR_W-1:0]     nal_header;

	modport source (output valid, output nal_address, output nal_header, input ready);
	modport sink (input valid, input nal_address, input nal_header, output ready);
endinterface

@@ rtl/abx_cfg_regs.sv @@
// window base and length configuration registers
module abx_cfg_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [abx_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [abx_pkg::CFG_W-1:0]       cfg_wdata,
	output abx_pkg::cfg_t                   cfg
);

	abx_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (abx_pkg::cfg_reg_t'(cfg_index))
				abx_pkg::REG_WINDOW_BASE: begin
					cfg_q.window_base <= cfg_wdata;
				end
				abx_pkg::REG_WINDOW_LENGTH: begin
					cfg_q.window_length <= cfg_wdata;
				end
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ rtl/abx_scan_core.sv @@
// scan state, start code detection and nal report generation
`include "assert_macros.svh"

module abx_scan_core #(
	parameter int HEADER_BYTES = 8,
	parameter int ADDR_BITS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          step,
	input  logic [abx_pkg::BYTE_W-1:0]    data_byte,
	input  logic                          restart,
	input  abx_pkg::cfg_t                 cfg,
	output abx_pkg::nal_rpt_t             rpt
);

	localparam int AW = (ADDR_BITS < abx_pkg::ADDR_W) ? ADDR_BITS : abx_pkg::ADDR_W;
	localparam logic [abx_pkg::ADDR_W-1:0] ADDR_MASK = {abx_pkg::ADDR_W{1'b1}} >>
		(abx_pkg::ADDR_W - AW);
	localparam logic [abx_pkg::ADDR_W-1:0] LAG = abx_pkg::ADDR_W'(HEADER_BYTES - 1);

	logic [abx_pkg::BYTE_W-1:0]      hist_q [abx_pkg::HIST_DEPTH];
	logic [abx_pkg::HIST_DEPTH-1:0]  marks_q;
	logic [abx_pkg::ADDR_W-1:0]      off_q;
	logic [1:0]                      zrun_q;

	logic [abx_pkg::BYTE_W-1:0]      hist_e [abx_pkg::HIST_DEPTH];
	logic [abx_pkg::HIST_DEPTH-1:0]  marks_e;
	logic [abx_pkg::ADDR_W-1:0]      off_e;
	logic [1:0]                      zrun_e;
	logic [abx_pkg::HDR_W-1:0]       hdr;
	logic [abx_pkg::ADDR_W-1:0]      poff;
	logic                            off_sat;
	logic                            again;
	logic                            code_end;

	// restart clears the scan before this word is looked at
	always_comb begin
		for (int k = 0; k < abx_pkg::HIST_DEPTH; k++) begin
			hist_e[k] = restart ? '0 : hist_q[k];
		end
		marks_e = restart ? '0 : marks_q;
		off_e = restart ? '0 : off_q;
		zrun_e = restart ? '0 : zrun_q;
	end

	always_comb begin
		hdr = '0;
		for (int j = 0; j < abx_pkg::HIST_DEPTH; j++) begin
			if (j < HEADER_BYTES - 1) begin
				hdr[abx_pkg::HDR_W-1-8*j -: 8] = hist_e[3'(HEADER_BYTES - 2 - j)];
			end else if (j == HEADER_BYTES - 1) begin
				hdr[abx_pkg::HDR_W-1-8*j -: 8] = data_byte;
			end
		end
	end

	assign off_sat = (off_e == {abx_pkg::ADDR_W{1'b1}});
	assign poff = off_e - LAG;
	// payload that opens with another start code is skipped
	assign again = (hdr[63:56] == 8'h00) && (hdr[55:48] == 8'h00) &&
		((hdr[47:40] == 8'h01) || ((hdr[47:40] == 8'h00) && (hdr[39:32] == 8'h01)));
	assign code_end = (data_byte == 8'h01) && (zrun_e >= 2'd2);

	always_comb begin
		rpt.hit = marks_e[HEADER_BYTES-1] && !off_sat && !again &&
			(poff < cfg.window_length);
		rpt.nal_address = (cfg.window_base + poff) & ADDR_MASK;
		rpt.nal_header = hdr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < abx_pkg::HIST_DEPTH; k++) begin
				hist_q[k] <= '0;
			end
			marks_q <= '0;
			off_q <= '0;
			zrun_q <= '0;
		end else if (step) begin
			hist_q[0] <= data_byte;
			for (int k = 1; k < abx_pkg::HIST_DEPTH; k++) begin
				hist_q[k] <= hist_e[k-1];
			end
			marks_q <= {marks_e[abx_pkg::HIST_DEPTH-2:0], code_end};
			if (data_byte == 8'h00) begin
				zrun_q <= (zrun_e == 2'd3) ? 2'd3 : zrun_e + 2'd1;
			end else begin
				zrun_q <= 2'd0;
			end
			off_q <= off_sat ? off_e : off_e + 1'b1;
		end
	end

	`ASSERT_IMPL(a_zrun_hist, clk, arst_n, zrun_q != 2'd0, hist_q[0] == 8'h00, "zero run without zero byte")
	`ASSERT_NEXT(a_off_count, clk, arst_n, step && !restart && !off_sat, off_q == $past(off_q) + 1'b1, "offset did not count")
	`ASSERT_IMPL(a_hit_window, clk, arst_n, rpt.hit, poff < cfg.window_length, "report outside window")

endmodule

@@ rtl/annexb_start_code_scanner_top.sv @@
// Pipeline: an accepted word is held in the input register and its nal report in the report register.
// Throughput: one byte per cycle while no stalled report holds the report register; the input register and the
// report register are separated so a stalled report does not stop the input while a slot is free.
// Reset: arst_n clears config to zero, the scan history, offset and valid flags.
// top level of the annex b start code scanner
`include "assert_macros.svh"

module annexb_start_code_scanner_top #(
	parameter int HEADER_BYTES = 8,
	parameter int ADDR_BITS = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [abx_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [abx_pkg::CFG_W-1:0]       cfg_wdata,
	abx_byte_if.sink                        byte_in,
	abx_nal_if.source                       nal_out
);

	abx_pkg::cfg_t                 cfg;
	abx_pkg::nal_rpt_t             rpt;

	logic                          valid_s1;
	logic [abx_pkg::BYTE_W-1:0]    byte_s1;
	logic                          restart_s1;
	logic                          adv_s1;
	logic                          out_valid_q;
	logic [abx_pkg::ADDR_W-1:0]    out_addr_q;
	logic [abx_pkg::HDR_W-1:0]     out_hdr_q;

	abx_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	abx_scan_core #(
		.HEADER_BYTES (HEADER_BYTES),
		.ADDR_BITS    (ADDR_BITS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (adv_s1),
		.data_byte (byte_s1),
		.restart   (restart_s1),
		.cfg       (cfg),
		.rpt       (rpt)
	);

	assign adv_s1 = valid_s1 && (!out_valid_q || nal_out.ready);
	assign byte_in.ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (byte_in.ready) begin
				valid_s1 <= byte_in.valid;
			end
			if (adv_s1) begin
				out_valid_q <= rpt.hit;
			end else if (nal_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (byte_in.valid && byte_in.ready) begin
			byte_s1 <= byte_in.data_byte;
			restart_s1 <= byte_in.restart;
		end
		if (adv_s1 && rpt.hit) begin
			out_addr_q <= rpt.nal_address;
			out_hdr_q <= rpt.nal_header;
		end
	end

	assign nal_out.valid = out_valid_q;
	assign nal_out.nal_address = out_addr_q;
	assign nal_out.nal_header = out_hdr_q;

	`ASSERT_IMPL(a_rise_after_adv, clk, arst_n, $rose(out_valid_q), $past(adv_s1), "report without advance")
	`ASSERT_IMPL(a_no_nested_code, clk, arst_n, out_valid_q, !((out_hdr_q[63:48] == 16'h0000) && (out_hdr_q[47:40] == 8'h01)), "report starts with start code")
	`ASSERT_IMPL(a_stall_holds_s1, clk, arst_n, !byte_in.ready, valid_s1 && out_valid_q, "input stalled without full pipe")

endmodule

@@ tb/tb.sv @@
// self-checking testbench for the annex b start code scanner
module tb;
	import abx_pkg::*;

	localparam int HDR_BYTES = 8;
	localparam int STALL_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 4;
	localparam int PHASE_BYTES = 120;

	class nal_report_board;
		typedef struct {
			logic [ADDR_W-1:0] addr;
			logic [HDR_W-1:0]  hdr;
		} nal_word_t;

		logic [BYTE_W-1:0] history [HIST_DEPTH];
		logic [7:0]        marks;
		logic [31:0]       offset;
		logic [1:0]        zero_run;
		logic [CFG_W-1:0]  base;
		logic [CFG_W-1:0]  span;
		nal_word_t         pending_reports [$];
		int                fails;

		function new();
			base = '0;
			span = '0;
			fails = 0;
			clear_scan();
		endfunction

		function void clear_scan();
			foreach (history[i]) history[i] = '0;
			marks = '0;
			offset = '0;
			zero_run = '0;
		endfunction

		function void set_reg(cfg_reg_t idx, logic [CFG_W-1:0] value);
			case (idx)
				REG_WINDOW_BASE: base = value;
				REG_WINDOW_LENGTH: span = value;
				default: ;
			endcase
		endfunction

		function int pending();
			return pending_reports.size();
		endfunction

		// accepted byte: advance the scan and queue a report when a header completes
		function void take_byte(logic [BYTE_W-1:0] b, logic restart);
			logic [HDR_W-1:0] hdr;
			logic [31:0]      poff;
			logic             again;
			nal_word_t        w;
			if (restart)
				clear_scan();
			if (marks[HDR_BYTES-1] && offset != 32'hFFFF_FFFF) begin
				hdr = '0;
				for (int k = HDR_BYTES - 2; k >= 0; k--)
					hdr = (hdr << 8) | HDR_W'(history[k]);
				hdr = (hdr << 8) | HDR_W'(b);
				hdr = hdr << (8 * (8 - HDR_BYTES));
				poff = offset - 32'(HDR_BYTES - 1);
				again = hdr[63:56] == 8'h00 && hdr[55:48] == 8'h00 &&
					(hdr[47:40] == 8'h01 || (hdr[47:40] == 8'h00 && hdr[39:32] == 8'h01));
				if (!again && poff < span) begin
					w.addr = base + poff;
					w.hdr = hdr;
					pending_reports.push_back(w);
				end
			end
			marks = {marks[6:0], b == 8'h01 && zero_run >= 2'd2};
			for (int k = HIST_DEPTH - 1; k > 0; k--)
				history[k] = history[k-1];
			history[0] = b;
			if (b == 8'h00)
				zero_run = (zero_run == 2'd3) ? 2'd3 : zero_run + 2'd1;
			else
				zero_run = 2'd0;
			if (offset != 32'hFFFF_FFFF)
				offset++;
		endfunction

		function void match_report(logic [ADDR_W-1:0] addr, logic [HDR_W-1:0] hdr);
			nal_word_t w;
			if (pending_reports.size() == 0) begin
				$error("unexpected nal word: nal_address %h nal_header %h", addr, hdr);
				fails++;
				return;
			end
			w = pending_reports.pop_front();
			if (addr !== w.addr) begin
				$error("nal_address: expected %h, got %h", w.addr, addr);
				fails++;
			end
			if (hdr !== w.hdr) begin
				$error("nal_header: expected %h, got %h", w.hdr, hdr);
				fails++;
			end
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_wdata;

	abx_byte_if byte_if();
	abx_nal_if  nal_if();

	annexb_start_code_scanner_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.byte_in   (byte_if),
		.nal_out   (nal_if)
	);

	nal_report_board board = new();
	int idle_pct;
	int stall_pct;
	int bytes_sent;
	int quiet_cycles;

	always #1 clk = ~clk;

	always @(negedge clk) begin
		nal_if.ready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && nal_if.valid && nal_if.ready)
			board.match_report(nal_if.nal_address, nal_if.nal_header);
	end

	always @(posedge clk) begin
		if ((byte_if.valid && byte_if.ready) || (nal_if.valid && nal_if.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	task automatic send_byte(input logic [BYTE_W-1:0] b, input logic restart);
		if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			byte_if.valid = 1'b0;
			do @(negedge clk); while ($urandom_range(99) < idle_pct);
		end
		byte_if.valid = 1'b1;
		byte_if.data_byte = b;
		byte_if.restart = restart;
		do @(posedge clk); while (!byte_if.ready);
		board.take_byte(b, restart);
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] value);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_wdata = value;
		@(negedge clk);
		cfg_we = 1'b0;
		board.set_reg(idx, value);
	endtask

	task automatic wait_drained();
		byte_if.valid = 1'b0;
		while (board.pending() > 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// random bytes, some with restart, or start codes of varying zero runs, then header bytes rich in 00 and 01
	task automatic send_scan_bytes(input int n);
		int stop;
		int hlen;
		int r;
		logic [BYTE_W-1:0] b;
		stop = bytes_sent + n;
		while (bytes_sent < stop) begin
			r = $urandom_range(99);
			if (r < 6) begin
				send_byte(8'($urandom_range(255)), 1'b1);
			end else if (r < 14) begin
				send_byte(8'($urandom_range(255)), 1'b0);
			end else begin
				do begin
					repeat (($urandom_range(3) == 0) ? $urandom_range(3, 5) : $urandom_range(2, 3))
						send_byte(8'h00, 1'b0);
					send_byte(8'h01, 1'b0);
				end while ($urandom_range(7) == 0);
				hlen = ($urandom_range(9) == 0) ? $urandom_range(0, 7) : $urandom_range(8, 12);
				for (int j = 0; j < hlen; j++) begin
					r = $urandom_range(7);
					b = (r == 0) ? 8'h00 : (r == 1) ? 8'h01 : 8'($urandom_range(255));
					send_byte(b, 1'b0);
				end
			end
		end
	endtask

	initial begin
		logic [BYTE_W-1:0] directed [$];
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_WINDOW_BASE;
		cfg_wdata = '0;
		byte_if.valid = 1'b0;
		byte_if.data_byte = '0;
		byte_if.restart = 1'b0;
		nal_if.ready = 1'b0;
		idle_pct = 0;
		stall_pct = 0;
		bytes_sent = 0;
		quiet_cycles = 0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: address wrap, long zero run, back to back start codes, cut-off header
		write_reg(REG_WINDOW_BASE, 32'hFFFF_FFF8);
		write_reg(REG_WINDOW_LENGTH, 32'hFFFF_FFFF);
		send_byte(8'h01, 1'b1);
		directed = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h01,
			8'h00, 8'h00, 8'h01, 8'hFF, 8'h80, 8'h7F, 8'h01, 8'hAA, 8'h55, 8'hFE, 8'h00,
			8'h00, 8'h00, 8'h01, 8'h11, 8'h22};
		foreach (directed[i])
			send_byte(directed[i], 1'b0);
		send_byte(8'h00, 1'b1);
		send_byte(8'h01, 1'b0);
		send_byte(8'h00, 1'b0);
		wait_drained();

		for (int p = 0; p < 6; p++) begin
			case (p % 4)
				0: begin idle_pct = 0; stall_pct = 0; end
				1: begin idle_pct = 87; stall_pct = 0; end
				2: begin idle_pct = 0; stall_pct = 87; end
				default: begin idle_pct = 21; stall_pct = 21; end
			endcase
			case (p)
				0: begin
					write_reg(REG_WINDOW_BASE, $urandom);
					write_reg(REG_WINDOW_LENGTH, 32'hFFFF_FFFF);
				end
				1: begin
					write_reg(REG_WINDOW_BASE, 32'hFFFF_FFFF);
					write_reg(REG_WINDOW_LENGTH, $urandom_range(20, 120));
				end
				3: begin
					write_reg(REG_WINDOW_BASE, $urandom);
					write_reg(REG_WINDOW_LENGTH, $urandom_range(1, 40));
				end
				4: begin
					write_reg(REG_WINDOW_BASE, 32'h0);
					write_reg(REG_WINDOW_LENGTH, 32'h0);
				end
				default: begin
					write_reg(REG_WINDOW_BASE, $urandom);
					write_reg(REG_WINDOW_LENGTH, 32'hFFFF_FFFF);
				end
			endcase
			send_byte(8'($urandom_range(255)), 1'b1);
			if (p == 2) begin
				send_scan_bytes(PHASE_BYTES / 2);
				wait_drained();
				send_scan_bytes(PHASE_BYTES / 2);
			end else begin
				send_scan_bytes(PHASE_BYTES);
			end
			wait_drained();
		end

		byte_if.valid = 1'b0;
		while (board.pending() > 0) @(negedge clk);
		repeat (8) @(posedge clk);
		if (board.fails == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule

@@ sim.f @@
+incdir+rtl
rtl/abx_pkg.sv
rtl/abx_if.sv
rtl/abx_cfg_regs.sv
rtl/abx_scan_core.sv
rtl/annexb_start_code_scanner_top.sv
tb/tb.sv
